// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BFD_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BFD_ASSERT(lbl, clk, rstn, prop, msg)
`define BFD_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/core/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Bezier forward difference package
// Widths, register codes and shared types of the tessellator.
// ----------------------------------------------------------------------------
package bfd_pkg;
  localparam int CW         = 32;   // coordinate width
  localparam int DW         = 50;   // difference term and quotient width
  localparam int BW         = 36;   // power-basis coefficient width
  localparam int RW         = 18;   // remainder width, holds M^3 - 1
  localparam int PTS_W      = 7;
  localparam int DEG_W      = 2;
  localparam int M_W        = 6;
  localparam int M2_W       = 12;
  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = 3;
  localparam int PDATA_W    = 32;

  localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(16);
  localparam logic [PTS_W-1:0] PTS_MIN   = PTS_W'(2);
  localparam logic [PTS_W-1:0] PTS_MAX   = PTS_W'(MAX_POINTS);

  localparam logic [DEG_W-1:0] DEG_NONE      = 2'd0;
  localparam logic [DEG_W-1:0] DEG_LINEAR    = 2'd1;
  localparam logic [DEG_W-1:0] DEG_QUADRATIC = 2'd2;
  localparam logic [DEG_W-1:0] DEG_CUBIC     = 2'd3;

  localparam logic REG_PTS = 1'b0;
  localparam logic REG_DEG = 1'b1;

  typedef struct packed {
    logic [PTS_W-1:0] pts;
    logic [DEG_W-1:0] deg;
  } cfg_t;
endpackage

// ===== rtl/core/bezier_forward_difference.sv =====
// Setup: after the input transaction the sequencer computes M^3, then for each coordinate the
// coefficients, the difference terms and their three divisions by M^3 on the shared divider.
// Then each point takes the three coordinate steps and the output transaction.
// A new segment is accepted only after the last point of the previous one has been taken.
// Reset: synchronous active-low rst_n clears the sequencer and output valid;
// registers return to 16 points, cubic.
// ----------------------------------------------------------------------------
// Bezier forward difference tessellator
// Splits each segment into evenly spaced points with exact forward differences.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bezier_forward_difference (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z
  input  logic [12*bfd_pkg::CW-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_x, out_y, out_z
  output logic [3*bfd_pkg::CW-1:0]      out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bfd_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [bfd_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [bfd_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import bfd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_M3   = 8'b0000_0010,
    S_COEF = 8'b0000_0100,
    S_TERM = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_WALK = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  cfg_t cfg;

  bfd_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  state_t                 state_r;
  logic [DEG_W-1:0]       deg_r;
  logic [M_W-1:0]         m_r, i_r;
  logic [M2_W-1:0]        m2_r;
  logic [RW-1:0]          m3_r;
  logic [1:0]             cix_r, k_r;
  logic                   div_go_r, last_r;
  logic signed [CW-1:0]   pa_r[3], pb_r[3], pc_r[3], pd_r[3], endp_r[3], out_r[3];
  logic signed [BW-1:0]   b0_r, b1_r, b2_r;
  logic signed [DW-1:0]   p0_r, p1_r;
  logic signed [DW-1:0]   dd_r[3];
  logic signed [DW-1:0]   pq_r[3], q0_r[3], q1_r[3], q2_r[3];
  logic [RW-1:0]          pr_r[3], r0_r[3], r1_r[3], r2_r[3];

  logic [PTS_W-1:0]       n_eff;
  logic signed [BW-1:0]   sa, sb, sc, sd, b0_nxt, b1_nxt, b2_nxt;
  logic signed [DW-1:0]   b2w;
  logic signed [BW+M2_W:0] p0_mul;
  logic signed [BW+M_W:0]  p1_mul;
  logic                   div_done;
  logic signed [DW-1:0]   div_q;
  logic [RW-1:0]          div_r;
  logic [RW:0]            s_p, s_0, s_1;
  logic                   c_p, c_0, c_1;
  logic signed [CW-1:0]   sat_v;

  always_comb begin
    if (cfg.pts < PTS_MIN) n_eff = PTS_MIN;
    else if (cfg.pts > PTS_MAX) n_eff = PTS_MAX;
    else n_eff = cfg.pts;
  end

  assign sa = BW'(pa_r[cix_r]);
  assign sb = BW'(pb_r[cix_r]);
  assign sc = BW'(pc_r[cix_r]);
  assign sd = BW'(pd_r[cix_r]);

  always_comb begin
    case (deg_r)
      DEG_QUADRATIC: begin
        b0_nxt = (sb - sa) <<< 1;
        b1_nxt = sa - (sb <<< 1) + sc;
        b2_nxt = '0;
      end
      DEG_CUBIC: begin
        b0_nxt = 3 * (sc - sa);
        b1_nxt = 3 * sa - 6 * sc + 3 * sd;
        b2_nxt = sb - sa + 3 * sc - 3 * sd;
      end
      default: begin
        b0_nxt = sb - sa;
        b1_nxt = '0;
        b2_nxt = '0;
      end
    endcase
  end

  assign b2w = DW'(b2_r);

  assign p0_mul = b0_r * $signed({1'b0, m2_r});
  assign p1_mul = b1_r * $signed({1'b0, m_r});

  bfd_div u_div (
    .clk, .rst_n, .go(div_go_r), .dividend(dd_r[k_r]), .divisor(m3_r),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  // Remainder carries keep every accumulator an exact quotient mod M^3.
  assign s_p = {1'b0, pr_r[cix_r]} + {1'b0, r0_r[cix_r]};
  assign s_0 = {1'b0, r0_r[cix_r]} + {1'b0, r1_r[cix_r]};
  assign s_1 = {1'b0, r1_r[cix_r]} + {1'b0, r2_r[cix_r]};
  assign c_p = s_p >= {1'b0, m3_r};
  assign c_0 = s_0 >= {1'b0, m3_r};
  assign c_1 = s_1 >= {1'b0, m3_r};

  always_comb begin
    if (pq_r[cix_r] > DW'(32'sh7FFF_FFFF)) sat_v = 32'sh7FFF_FFFF;
    else if (pq_r[cix_r] < -DW'(64'sh8000_0000)) sat_v = 32'sh8000_0000;
    else sat_v = CW'(pq_r[cix_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          for (int c = 0; c < 3; c++) begin
            pa_r[c] <= in_tdata[c*CW +: CW];
            pb_r[c] <= in_tdata[(3+c)*CW +: CW];
            pc_r[c] <= in_tdata[(6+c)*CW +: CW];
            pd_r[c] <= in_tdata[(9+c)*CW +: CW];
          end
          deg_r   <= (cfg.deg == DEG_NONE) ? DEG_LINEAR : cfg.deg;
          m_r     <= M_W'(n_eff - 1'b1);
          m2_r    <= M2_W'(n_eff - 1'b1) * M2_W'(n_eff - 1'b1);
          state_r <= S_M3;
        end
        S_M3: begin
          m3_r    <= RW'(m2_r) * RW'(m_r);
          cix_r   <= '0;
          state_r <= S_COEF;
        end
        S_COEF: begin
          b0_r <= b0_nxt;
          b1_r <= b1_nxt;
          b2_r <= b2_nxt;
          endp_r[cix_r] <= (deg_r == DEG_QUADRATIC) ? pc_r[cix_r] : pb_r[cix_r];
          pq_r[cix_r]   <= DW'(pa_r[cix_r]);
          pr_r[cix_r]   <= '0;
          state_r <= S_TERM;
        end
        S_TERM: begin
          p0_r    <= DW'(p0_mul);
          p1_r    <= DW'(p1_mul);
          state_r <= S_SUM;
        end
        S_SUM: begin
          dd_r[0]  <= p0_r + p1_r + b2w;
          dd_r[1]  <= (p1_r <<< 1) + (b2w <<< 2) + (b2w <<< 1);
          dd_r[2]  <= (b2w <<< 2) + (b2w <<< 1);
          k_r      <= '0;
          div_go_r <= 1'b1;
          state_r  <= S_DIV;
        end
        S_DIV: if (div_done) begin
          case (k_r)
            2'd0: begin q0_r[cix_r] <= div_q; r0_r[cix_r] <= div_r; end
            2'd1: begin q1_r[cix_r] <= div_q; r1_r[cix_r] <= div_r; end
            default: begin q2_r[cix_r] <= div_q; r2_r[cix_r] <= div_r; end
          endcase
          if (k_r == 2'd2) begin
            if (cix_r == 2'd2) begin
              cix_r   <= '0;
              i_r     <= '0;
              state_r <= S_WALK;
            end else begin
              cix_r   <= cix_r + 1'b1;
              state_r <= S_COEF;
            end
          end else begin
            k_r      <= k_r + 1'b1;
            div_go_r <= 1'b1;
          end
        end
        S_WALK: begin
          out_r[cix_r] <= (i_r == m_r) ? endp_r[cix_r] : sat_v;
          pr_r[cix_r]  <= c_p ? RW'(s_p - {1'b0, m3_r}) : RW'(s_p);
          pq_r[cix_r]  <= pq_r[cix_r] + q0_r[cix_r] + DW'(c_p);
          r0_r[cix_r]  <= c_0 ? RW'(s_0 - {1'b0, m3_r}) : RW'(s_0);
          q0_r[cix_r]  <= q0_r[cix_r] + q1_r[cix_r] + DW'(c_0);
          r1_r[cix_r]  <= c_1 ? RW'(s_1 - {1'b0, m3_r}) : RW'(s_1);
          q1_r[cix_r]  <= q1_r[cix_r] + q2_r[cix_r] + DW'(c_1);
          if (cix_r == 2'd2) begin
            last_r  <= (i_r == m_r);
            state_r <= S_OUT;
          end else begin
            cix_r <= cix_r + 1'b1;
          end
        end
        S_OUT: if (out_tready) begin
          if (last_r) begin
            state_r <= S_IDLE;
          end else begin
            i_r     <= i_r + 1'b1;
            cix_r   <= '0;
            state_r <= S_WALK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {out_r[2], out_r[1], out_r[0]};
  assign out_tlast  = last_r;

  `BFD_NEVER(a_one_side, clk, rst_n, in_tready && out_tvalid, "input and output both open")
  `BFD_ASSERT(a_last_idx, clk, rst_n, out_tvalid && out_tlast |-> (i_r == m_r), "early last")
  `BFD_ASSERT(a_back_idle, clk, rst_n, out_tvalid && out_tready && out_tlast |=> in_tready, "no idle after last")
  `BFD_NEVER(a_div_state, clk, rst_n, div_go_r && (state_r != S_DIV), "divider start outside setup")
endmodule

// ===== rtl/core/bfd_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding point count and curve degree.
// ----------------------------------------------------------------------------
module bfd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bfd_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [bfd_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [bfd_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output bfd_pkg::cfg_t                cfg
);
  import bfd_pkg::*;

  logic [PTS_W-1:0] pts_r;
  logic [DEG_W-1:0] deg_r;
  logic             wr_en;

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= PTS_RESET;
      deg_r <= DEG_CUBIC;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        REG_PTS: pts_r <= cfg_pwdata[PTS_W-1:0];
        REG_DEG: deg_r <= cfg_pwdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_PTS: cfg_prdata = PDATA_W'(pts_r);
      REG_DEG: cfg_prdata = PDATA_W'(deg_r);
      default: cfg_prdata = '0;
    endcase
  end

  assign cfg.pts = pts_r;
  assign cfg.deg = deg_r;
endmodule

// ===== rtl/core/bfd_div.sv =====
// ----------------------------------------------------------------------------
// Floor divider
// Restoring divider, one quotient bit per cycle, floor quotient and
// non-negative remainder of a signed dividend by an unsigned divisor.
// ----------------------------------------------------------------------------
module bfd_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic signed [bfd_pkg::DW-1:0]   dividend,
  input  logic [bfd_pkg::RW-1:0]          divisor,
  output logic                            done,
  output logic signed [bfd_pkg::DW-1:0]   quot,
  output logic [bfd_pkg::RW-1:0]          rem
);
  import bfd_pkg::*;

  localparam int CNT_W = $clog2(DW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [DW-1:0]    mag_r, mag_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    dvs_r, dvs_nxt;
  logic [RW:0]      trial;
  logic             ge;

  assign trial = {rem_r, mag_r[DW-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW - 1);
      neg_nxt  = dividend[DW-1];
      mag_nxt  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? RW'(trial - {1'b0, dvs_r}) : RW'(trial);
      mag_nxt = {mag_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // A negative dividend with a nonzero remainder rounds one further down.
  always_comb begin
    if (neg_r && (rem_r != '0)) begin
      quot = $signed(~mag_r);
      rem  = dvs_r - rem_r;
    end else if (neg_r) begin
      quot = $signed(-mag_r);
      rem  = '0;
    end else begin
      quot = $signed(mag_r);
      rem  = rem_r;
    end
  end

  assign done = done_r;
endmodule

// ===== sim/bezier_forward_difference_tb.sv =====
// ----------------------------------------------------------------------------
// Bezier forward difference testbench
// Drives control-point transactions and register writes into the tessellator.
// A scoreboard computes the exact tessellated points and compares every
// output transaction with them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class point_scoreboard;
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } point_t;

  point_t pending[$];
  int     errors;
  int     points_seen;
  int     segments_seen;
  logic [6:0] pts_reg;
  logic [1:0] deg_reg;

  function new();
    errors = 0;
    points_seen = 0;
    segments_seen = 0;
    pts_reg = 7'd16;
    deg_reg = bfd_pkg::DEG_CUBIC;
  endfunction

  function longint floor_div(longint q, longint d);
    if (q >= 0) return q / d;
    return -((-q + d - 1) / d);
  endfunction

  // Works out every point of one segment and queues them.
  function void note_segment(logic [12*32-1:0] data);
    longint n, m, m2, m3, a, b, cc, d, b0, b1, b2;
    longint acc[3], d0[3], d1[3], d2[3], endp[3];
    logic [6:0] deg;
    point_t p;
    logic [31:0] v[3];
    n = pts_reg;
    if (n < 2) n = 2;
    if (n > bfd_pkg::MAX_POINTS) n = bfd_pkg::MAX_POINTS;
    deg = (deg_reg == bfd_pkg::DEG_NONE) ? bfd_pkg::DEG_LINEAR : deg_reg;
    m = n - 1;
    m2 = m * m;
    m3 = m2 * m;
    for (int c = 0; c < 3; c++) begin
      a  = longint'($signed(data[32*c +: 32]));
      b  = longint'($signed(data[32*(3+c) +: 32]));
      cc = longint'($signed(data[32*(6+c) +: 32]));
      d  = longint'($signed(data[32*(9+c) +: 32]));
      if (deg == bfd_pkg::DEG_LINEAR) begin
        b0 = b - a; b1 = 0; b2 = 0; endp[c] = b;
      end else if (deg == bfd_pkg::DEG_QUADRATIC) begin
        b0 = 2 * (b - a); b1 = a - 2 * b + cc; b2 = 0; endp[c] = cc;
      end else begin
        b0 = 3 * (cc - a); b1 = 3 * a - 6 * cc + 3 * d;
        b2 = b - a + 3 * cc - 3 * d; endp[c] = b;
      end
      acc[c] = a * m3;
      d0[c] = b0 * m2 + b1 * m + b2;
      d1[c] = 2 * b1 * m + 6 * b2;
      d2[c] = 6 * b2;
    end
    for (longint i = 0; i < n; i++) begin
      for (int c = 0; c < 3; c++) begin
        longint r;
        r = (i == n - 1) ? endp[c] : floor_div(acc[c], m3);
        // Interior points of a wild cubic can leave the coordinate range.
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        v[c] = r[31:0];
        acc[c] += d0[c];
        d0[c] += d1[c];
        d1[c] += d2[c];
      end
      p.x = v[0]; p.y = v[1]; p.z = v[2];
      p.last = (i == n - 1);
      pending = {pending, p};
    end
  endfunction

  function void check_point(logic [3*32-1:0] data, logic last);
    point_t e;
    points_seen++;
    if (last) segments_seen++;
    if (pending.size() == 0) begin
      $error("unexpected point transaction x=%h y=%h z=%h", data[31:0], data[63:32],
             data[95:64]);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (data[31:0] !== e.x) begin
      $error("out_x expected %h actual %h", e.x, data[31:0]); errors++;
    end
    if (data[63:32] !== e.y) begin
      $error("out_y expected %h actual %h", e.y, data[63:32]); errors++;
    end
    if (data[95:64] !== e.z) begin
      $error("out_z expected %h actual %h", e.z, data[95:64]); errors++;
    end
    if (last !== e.last) begin
      $error("last_point expected %0b actual %0b", e.last, last); errors++;
    end
  endfunction
endclass

module bezier_forward_difference_tb;
  import bfd_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [12*CW-1:0]    in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [3*CW-1:0]     out_tdata;
  logic                out_tlast;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [PDATA_W-1:0]  cfg_pwdata;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;

  point_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int segments_sent;

  bezier_forward_difference u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("bezier_forward_difference verification failed");
    $finish;
  end

  // Result side: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_point(out_tdata, out_tlast);
  end

  task automatic write_reg(input logic index, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_W'(4 * index); cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (index == REG_PTS) sb.pts_reg = value[6:0];
    else sb.deg_reg = value[1:0];
  endtask

  task automatic send_segment(input logic [12*CW-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_segment(data);
    segments_sent++;
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(32'h0003_0000);
      3: return -$urandom_range(32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [12*CW-1:0] rand_segment();
    logic [12*CW-1:0] s;
    for (int k = 0; k < 12; k++) s[32*k +: 32] = rand_coord();
    return s;
  endfunction

  function automatic logic [12*CW-1:0] fill_segment(input logic [31:0] v);
    logic [12*CW-1:0] s;
    for (int k = 0; k < 12; k++) s[32*k +: 32] = v;
    return s;
  endfunction

  task automatic random_phase(input int count, input int sidle, input int ridle);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int k = 0; k < count; k++) begin
      // Small point counts keep most segments short; extremes appear now and then.
      if (k % 11 == 0) begin
        drain();
        case ($urandom_range(5))
          0: write_reg(REG_PTS, 32'd64);
          1: write_reg(REG_PTS, 32'd2);
          2: write_reg(REG_PTS, $urandom_range(127));
          default: write_reg(REG_PTS, $urandom_range(3, 12));
        endcase
        write_reg(REG_DEG, $urandom_range(3));
      end
      send_segment(rand_segment());
    end
    drain();
  endtask

  initial begin
    logic [12*CW-1:0] seg;
    sb = new();
    segments_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, then each degree with edge values and counts.
    send_segment(fill_segment(32'h8000_0000));
    send_segment(fill_segment(32'h7fff_ffff));
    seg = fill_segment(32'h8000_0000);
    seg[32*3 +: 96] = {3{32'h7fff_ffff}};
    send_segment(seg);
    drain();
    for (int dg = 0; dg < 4; dg++) begin
      write_reg(REG_DEG, dg);
      seg = '0;
      write_reg(REG_PTS, 32'd2);
      send_segment(rand_segment());
      drain();
      write_reg(REG_PTS, 32'd64);
      seg = {4{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000}};
      send_segment(seg);
      send_segment(~seg);
      drain();
    end
    // Point counts outside the legal range are clamped.
    write_reg(REG_PTS, 32'd0);
    send_segment(rand_segment());
    drain();
    write_reg(REG_PTS, 32'd1);
    send_segment(rand_segment());
    drain();
    write_reg(REG_PTS, 32'd127);
    send_segment(rand_segment());
    drain();
    write_reg(REG_PTS, 32'hffff_ff41);
    write_reg(REG_DEG, 32'hffff_fffe);
    send_segment(rand_segment());
    drain();

    // Long receiver hold-off while the sender keeps offering segments.
    write_reg(REG_PTS, 32'd8);
    write_reg(REG_DEG, DEG_CUBIC);
    fork
      hold_cycles = 3000;
      for (int k = 0; k < 6; k++) send_segment(rand_segment());
    join
    drain();

    random_phase(80, 13, 72);
    random_phase(80, 72, 13);
    random_phase(80, 0, 0);

    $display("Covered %0d segments and %0d points over all degrees and point counts 0..127.",
             segments_sent, sb.points_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("bezier_forward_difference verification clean");
    else
      $display("bezier_forward_difference verification failed");
    $finish;
  end
endmodule
